>>> rtl/midi_szr_pkg.sv
`default_nettype none

package midi_szr_pkg;

    // Field widths
    localparam int STATUS_W   = 8;
    localparam int DATA_W     = 7;
    localparam int LENGTH_W   = 2;
    localparam int TIME_W     = 16;
    localparam int PORT_W     = 3;
    localparam int KIND_W     = 4;
    localparam int CHANNEL_W  = 4;

    // Strip settings and configuration port
    localparam int NUM_STRIPS_DEF = 11;
    localparam int SETTING_STRIPS = 11;
    localparam int STRIP_BITS     = 26;
    localparam int CFG_DATA_W     = 2 * STRIP_BITS;
    localparam int CFG_ADDR_W     = 3;
    localparam int NUM_PAIR_REGS  = SETTING_STRIPS / 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STRIP_SINGLE = 3'd5;

    // Strips that share the first output port
    localparam int PORT0_STRIPS = 8;

    // Message codes
    localparam logic [KIND_W-1:0]    KIND_NOTE_OFF = 4'h8;
    localparam logic [KIND_W-1:0]    KIND_NOTE_ON  = 4'h9;
    localparam logic [KIND_W-1:0]    KIND_CONTROL  = 4'hB;
    localparam logic [CHANNEL_W-1:0] CHANNEL_16    = 4'hF;
    localparam logic [STATUS_W-1:0]  STATUS_CC_CH1   = 8'hB0;
    localparam logic [STATUS_W-1:0]  STATUS_BEND_CH1 = 8'hE0;
    localparam logic [PORT_W-1:0]    PORT_CONTROL    = 3'd4;
    localparam logic [DATA_W-1:0]    DATA_MAX        = 7'h7F;

    typedef struct packed {
        logic [STATUS_W-1:0] status_byte;
        logic [DATA_W-1:0]   data_first;
        logic [DATA_W-1:0]   data_second;
        logic [LENGTH_W-1:0] msg_length;
        logic [TIME_W-1:0]   time_offset;
    } t_msg_word;

    typedef struct packed {
        logic [PORT_W-1:0]   out_port;
        logic [STATUS_W-1:0] out_status;
        logic [DATA_W-1:0]   out_first;
        logic [DATA_W-1:0]   out_second;
        logic [LENGTH_W-1:0] out_length;
        logic [TIME_W-1:0]   out_time;
        logic                last_copy;
    } t_route_word;

    // One strip's settings, bit 0 is enable
    typedef struct packed {
        logic [DATA_W-1:0]    transpose;
        logic [CHANNEL_W-1:0] channel;
        logic [DATA_W-1:0]    key_high;
        logic [DATA_W-1:0]    key_low;
        logic                 enable;
    } t_strip_cfg;

    // Chain control broadcast to every cell
    typedef struct packed {
        logic load;
        logic shift;
        logic cc16;
    } t_chain_ctrl;

endpackage

`default_nettype wire

>>> rtl/midi_split_zone_router.sv
`default_nettype none

// MIDI split-zone router. Each accepted word is held in an input register and,
// once the cell chain has drained, loaded into a row of NUM_STRIPS cells all at
// once: every enabled strip whose key range holds data_first (or any enabled strip
// for status 0xB0 or 0xE0) writes its rechanneled copy, transposed for notes, into
// its cell, and a channel-16 control change loads only the head cell with a port-4
// copy. The chain then shifts one cell per cycle toward the head cell, which is the
// output register, whenever the head is empty or taken, so copies leave one per
// cycle in strip order while the receiver is ready, with last_copy on the final
// one. A word occupies the chain until its last copy has left, because empty
// cells below it shift through too; the next word is taken into the input
// register while the chain is still emptying and loads in the cycle the last copy
// leaves. Strip settings are written through i_cfg_we/i_cfg_addr/i_cfg_data:
// registers 0 to 4 hold two strips each (even strip in bits 25:0), register 5 holds
// strip 10; all strips come out of reset disabled.
module midi_split_zone_router #(
    parameter int NUM_STRIPS = midi_szr_pkg::NUM_STRIPS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  midi_szr_pkg::t_msg_word                 i_msg,
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output midi_szr_pkg::t_route_word               o_route,
    input  wire                                     i_cfg_we,
    input  wire [midi_szr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [midi_szr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import midi_szr_pkg::*;

    t_strip_cfg      r_strip_cfg [SETTING_STRIPS];
    t_msg_word       r_msg;
    logic            r_msg_valid;

    t_chain_ctrl     ctrl;
    t_strip_cfg      cell_cfg  [NUM_STRIPS];
    t_route_word     chain_copy [NUM_STRIPS+1];
    logic [NUM_STRIPS:0] chain_valid;
    logic [NUM_STRIPS:0] chain_hit;
    logic [NUM_STRIPS:0] chain_busy;
    logic            in_accept;

    // Write strip settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETTING_STRIPS; s++) begin
                r_strip_cfg[s] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int p = 0; p < NUM_PAIR_REGS; p++) begin
                if (i_cfg_addr == CFG_ADDR_W'(p)) begin
                    r_strip_cfg[2*p]   <= i_cfg_data[STRIP_BITS-1:0];
                    r_strip_cfg[2*p+1] <= i_cfg_data[CFG_DATA_W-1:STRIP_BITS];
                end
            end
            if (i_cfg_addr == REG_STRIP_SINGLE) begin
                r_strip_cfg[SETTING_STRIPS-1] <= i_cfg_data[STRIP_BITS-1:0];
            end
        end
    end

    // Advance when the head is empty or taken; load once the rest has drained
    always_comb begin
        ctrl.shift = !chain_valid[0] || i_out_ready;
        ctrl.load  = ctrl.shift && r_msg_valid && !chain_busy[1];
        ctrl.cc16  = (r_msg.status_byte[STATUS_W-1:STATUS_W-KIND_W] == KIND_CONTROL) &&
                     (r_msg.status_byte[CHANNEL_W-1:0] == CHANNEL_16);
    end

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_msg_valid || ctrl.load;

    // Hold the incoming word until the chain takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_valid <= 1'b0;
        end else if (in_accept) begin
            r_msg_valid <= 1'b1;
        end else if (ctrl.load) begin
            r_msg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_msg <= i_msg;
        end
    end

    // Terminate the chain past the last cell
    assign chain_valid[NUM_STRIPS] = 1'b0;
    assign chain_copy[NUM_STRIPS]  = '0;
    assign chain_hit[NUM_STRIPS]   = 1'b0;
    assign chain_busy[NUM_STRIPS]  = 1'b0;

    for (genvar k = 0; k < NUM_STRIPS; k++) begin : g_cell
        if (k < SETTING_STRIPS) begin : g_set
            assign cell_cfg[k] = r_strip_cfg[k];
        end else begin : g_none
            assign cell_cfg[k] = '0;
        end

        midi_szr_cell #(
            .STRIP_IDX (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_msg        (r_msg),
            .i_cfg        (cell_cfg[k]),
            .i_next_valid (chain_valid[k+1]),
            .i_next_copy  (chain_copy[k+1]),
            .i_hit_above  (chain_hit[k+1]),
            .i_busy_above (chain_busy[k+1]),
            .o_valid      (chain_valid[k]),
            .o_copy       (chain_copy[k]),
            .o_hit_chain  (chain_hit[k]),
            .o_busy_chain (chain_busy[k])
        );
    end

    assign o_out_valid = chain_valid[0];
    assign o_route     = chain_copy[0];

`ifndef SYNTHESIS
    // A pass-through control copy is a word's only result
    a_cc_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_route.out_port == PORT_CONTROL) |-> !chain_busy[1])
        else $error("control copy shares the chain with other copies");

    a_cc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_route.out_port == PORT_CONTROL) |-> o_route.last_copy)
        else $error("control copy not marked last");

    a_msg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_msg_valid && !ctrl.load |=> r_msg_valid)
        else $error("held word dropped before loading");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_route.last_copy |-> !chain_busy[1])
        else $error("copies remain behind the last copy");
`endif

endmodule

`default_nettype wire

>>> rtl/midi_szr_cell.sv
`default_nettype none

module midi_szr_cell #(
    parameter int STRIP_IDX = 0
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  midi_szr_pkg::t_chain_ctrl  i_ctrl,
    input  midi_szr_pkg::t_msg_word    i_msg,
    input  midi_szr_pkg::t_strip_cfg   i_cfg,
    input  wire                        i_next_valid,
    input  midi_szr_pkg::t_route_word  i_next_copy,
    input  wire                        i_hit_above,
    input  wire                        i_busy_above,
    output logic                       o_valid,
    output midi_szr_pkg::t_route_word  o_copy,
    output logic                       o_hit_chain,
    output logic                       o_busy_chain
);
    import midi_szr_pkg::*;

    localparam bit IsHead  = (STRIP_IDX == 0);
    localparam int PortNum = (STRIP_IDX < PORT0_STRIPS) ? 0 : STRIP_IDX - PORT0_STRIPS + 1;
    localparam logic [PORT_W-1:0] CellPort = PORT_W'(PortNum);

    logic              r_valid;
    logic              n_valid;
    t_route_word       r_copy;
    t_route_word       n_copy;

    logic [KIND_W-1:0] kind;
    logic              is_note;
    logic              any_key;
    logic              in_range;
    logic              hit;
    logic              bypass;
    logic [DATA_W+1:0] sum;
    logic [DATA_W-1:0] moved_key;
    t_route_word       strip_copy;
    t_route_word       cc_copy;

    // Decide whether this strip takes the word
    always_comb begin
        kind     = i_msg.status_byte[STATUS_W-1:STATUS_W-KIND_W];
        is_note  = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);
        any_key  = (i_msg.status_byte == STATUS_CC_CH1) ||
                   (i_msg.status_byte == STATUS_BEND_CH1);
        in_range = (i_cfg.key_low <= i_msg.data_first) &&
                   (i_msg.data_first <= i_cfg.key_high);
        hit      = i_cfg.enable && (any_key || in_range) && !i_ctrl.cc16;
        bypass   = IsHead && i_ctrl.cc16;
    end

    // Transpose and clamp the note number
    always_comb begin
        sum = {2'b00, i_msg.data_first} +
              {{2{i_cfg.transpose[DATA_W-1]}}, i_cfg.transpose};
        if (sum[DATA_W+1]) begin
            moved_key = '0;
        end else if (sum[DATA_W]) begin
            moved_key = DATA_MAX;
        end else begin
            moved_key = sum[DATA_W-1:0];
        end
    end

    // Build this strip's copy and the channel-16 pass-through copy
    always_comb begin
        strip_copy.out_port   = CellPort;
        strip_copy.out_status = {kind, i_cfg.channel};
        strip_copy.out_first  = is_note ? moved_key : i_msg.data_first;
        strip_copy.out_second = i_msg.data_second;
        strip_copy.out_length = i_msg.msg_length;
        strip_copy.out_time   = i_msg.time_offset;
        strip_copy.last_copy  = !i_hit_above;

        cc_copy.out_port      = PORT_CONTROL;
        cc_copy.out_status    = i_msg.status_byte;
        cc_copy.out_first     = i_msg.data_first;
        cc_copy.out_second    = i_msg.data_second;
        cc_copy.out_length    = i_msg.msg_length;
        cc_copy.out_time      = i_msg.time_offset;
        cc_copy.last_copy     = 1'b1;
    end

    // Load a fresh copy, or take the neighbor's as the chain advances
    always_comb begin
        n_valid = r_valid;
        n_copy  = r_copy;
        if (i_ctrl.load) begin
            n_valid = bypass || hit;
            n_copy  = bypass ? cc_copy : strip_copy;
        end else if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_copy  = i_next_copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy <= n_copy;
    end

    assign o_valid      = r_valid;
    assign o_copy       = r_copy;
    assign o_hit_chain  = hit || i_hit_above;
    assign o_busy_chain = r_valid || i_busy_above;

endmodule

`default_nettype wire

>>> verif/tb_midi_split_zone_router.sv
module tb_midi_split_zone_router;
    timeunit 1ns;
    timeprecision 1ps;

    import midi_szr_pkg::*;

    localparam int IDLE_PCT      = 9;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 2 * NUM_STRIPS_DEF + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 44;
    localparam int OFF_ITEMS     = 20;
    localparam int PRESSURE_PHASE = 1;
    localparam int STEADY_PHASE   = 2;

    // Register indexes: pairs start at zero, strip 10 sits at REG_STRIP_SINGLE
    localparam logic [CFG_ADDR_W-1:0] REG_PAIR_0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_check;
    typedef enum logic [2:0] {SET_ZONES, SET_RANDOM, SET_WIDE, SET_ALL_ONES, SET_OFF} t_preset;

    typedef struct {
        t_msg_word   msg;
        t_check      mode;
        t_route_word copy;
        bit          zones;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_msg_word             i_msg = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_route_word           o_route;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_strip_cfg  strip_set [NUM_STRIPS_DEF];
    t_strip_cfg  plan_set  [NUM_STRIPS_DEF];
    t_route_word due_copies [$];
    t_row        dir_rows [$];
    t_preset     phase_set [NUM_PHASES] =
        '{SET_RANDOM, SET_WIDE, SET_RANDOM, SET_OFF, SET_ALL_ONES, SET_RANDOM};

    int fail_count   = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = IDLE_PCT;
    int rx_idle_pct  = IDLE_PCT;
    bit hold_req     = 1'b0;
    bit zones_loaded = 1'b0;

    midi_split_zone_router dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_msg       (i_msg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_route     (o_route),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_msg_word mk_msg(input logic [STATUS_W-1:0] st,
                                         input logic [DATA_W-1:0] d1,
                                         input logic [DATA_W-1:0] d2,
                                         input logic [LENGTH_W-1:0] len,
                                         input logic [TIME_W-1:0] tm);
        return {st, d1, d2, len, tm};
    endfunction

    function automatic t_route_word mk_copy(input logic [PORT_W-1:0] port,
                                            input t_msg_word m);
        return {port, m.status_byte, m.data_first, m.data_second, m.msg_length,
                m.time_offset, 1'b1};
    endfunction

    function automatic t_strip_cfg mk_strip(input bit en, input int lo, input int hi,
                                            input int ch, input int tr);
        t_strip_cfg c;
        c.enable    = en;
        c.key_low   = DATA_W'(lo);
        c.key_high  = DATA_W'(hi);
        c.channel   = CHANNEL_W'(ch);
        c.transpose = DATA_W'(tr);
        return c;
    endfunction

    // Append one directed row to the stimulus table
    function automatic void add_row(input t_msg_word m, input t_check mode,
                                    input t_route_word typed, input bit zones);
        t_row r;
        r.msg   = m;
        r.mode  = mode;
        r.copy  = typed;
        r.zones = zones;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Queue one copy at the back of the due list
    function automatic void queue_copy(input t_route_word c);
        due_copies.insert(due_copies.size(), c);
    endfunction

    // Expand one message into its routed copies, in strip order
    function automatic void split_message(input t_msg_word m);
        t_route_word batch [$];
        t_route_word c;
        logic [KIND_W-1:0] kind;
        bit any_key;
        bit is_note;
        int v;
        int tr;
        kind         = m.status_byte[7:4];
        c.out_second = m.data_second;
        c.out_length = m.msg_length;
        c.out_time   = m.time_offset;
        // Channel-16 control bypasses the strips
        if (kind == KIND_CONTROL && m.status_byte[3:0] == CHANNEL_16) begin
            queue_copy(mk_copy(PORT_CONTROL, m));
            return;
        end
        any_key = (m.status_byte == STATUS_CC_CH1) || (m.status_byte == STATUS_BEND_CH1);
        is_note = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);
        for (int s = 0; s < NUM_STRIPS_DEF; s++) begin
            if (!strip_set[s].enable) continue;
            if (!(any_key || (m.data_first >= strip_set[s].key_low &&
                              m.data_first <= strip_set[s].key_high))) continue;
            c.out_first = m.data_first;
            if (is_note) begin
                tr = $signed(strip_set[s].transpose);
                v  = int'(m.data_first) + tr;
                if (v < 0) v = 0;
                if (v > int'(DATA_MAX)) v = int'(DATA_MAX);
                c.out_first = DATA_W'(v);
            end
            c.out_port   = (s < PORT0_STRIPS) ? '0 : PORT_W'(s - PORT0_STRIPS + 1);
            c.out_status = {kind, strip_set[s].channel};
            c.last_copy  = 1'b0;
            batch.insert(batch.size(), c);
        end
        if (batch.size() > 0) batch[batch.size()-1].last_copy = 1'b1;
        foreach (batch[i]) queue_copy(batch[i]);
    endfunction

    // Compare one accepted copy against the oldest one due
    function automatic void check_copy(input t_route_word got);
        t_route_word want;
        bit bad;
        if (due_copies.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("unexpected copy: port %0d status %h first %h second %h len %0d",
                         got.out_port, got.out_status, got.out_first, got.out_second,
                         got.out_length);
            return;
        end
        want = due_copies.pop_front();
        bad = (got.out_port !== want.out_port) || (got.out_status !== want.out_status) ||
              (got.out_first !== want.out_first) || (got.out_second !== want.out_second) ||
              (got.out_length !== want.out_length) || (got.out_time !== want.out_time) ||
              (got.last_copy !== want.last_copy);
        if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $write("copy mismatch (exp/got): port %0d/%0d status %h/%h first %h/%h",
                       want.out_port, got.out_port, want.out_status, got.out_status,
                       want.out_first, got.out_first);
                $display(" second %h/%h len %0d/%0d time %h/%h last %b/%b",
                         want.out_second, got.out_second, want.out_length, got.out_length,
                         want.out_time, got.out_time, want.last_copy, got.last_copy);
            end
        end
    endfunction

    function automatic t_strip_cfg rand_strip();
        t_strip_cfg c;
        int r;
        c.enable   = ($urandom_range(99) < 75);
        c.key_low  = DATA_W'($urandom());
        c.key_high = DATA_W'($urandom());
        r = $urandom_range(99);
        if (r < 70) begin
            if (c.key_low > c.key_high) {c.key_low, c.key_high} = {c.key_high, c.key_low};
        end else if (r < 85) begin
            c.key_low  = '0;
            c.key_high = DATA_MAX;
        end
        c.channel = CHANNEL_W'($urandom());
        r = $urandom_range(99);
        if (r < 10)      c.transpose = DATA_W'(-64);
        else if (r < 20) c.transpose = DATA_W'(63);
        else             c.transpose = DATA_W'($urandom());
        return c;
    endfunction

    function automatic void fill_plan(input t_preset p);
        for (int s = 0; s < NUM_STRIPS_DEF; s++) begin
            case (p)
                SET_RANDOM:   plan_set[s] = rand_strip();
                SET_WIDE:     plan_set[s] = mk_strip(1'b1, 0, 127, int'($urandom_range(15)),
                                                     (s % 2 == 1) ? 63 : -64);
                SET_ALL_ONES: plan_set[s] = '1;
                default:      plan_set[s] = '0;
            endcase
        end
        if (p == SET_ZONES) begin
            plan_set[0]  = mk_strip(1'b1,   0,  63,  0,  63);
            plan_set[1]  = mk_strip(1'b1,  64, 127, 15, -64);
            plan_set[2]  = mk_strip(1'b1, 100,  20,  3,   5);
            plan_set[3]  = mk_strip(1'b0,   0, 127,  2,   7);
            plan_set[4]  = mk_strip(1'b1,  60,  60,  4,   0);
            plan_set[5]  = mk_strip(1'b1,   0, 127,  5,  -1);
            plan_set[7]  = mk_strip(1'b1, 127, 127,  7,   1);
            plan_set[8]  = mk_strip(1'b1,   0,   0,  8, -64);
            plan_set[9]  = mk_strip(1'b1,   0, 127,  9,  12);
            plan_set[10] = mk_strip(1'b1,  40,  80, 10, -12);
        end
    endfunction

    // Write one register at the next edge and mirror it in the local strip copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int ri;
        ri = int'(idx);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < REG_STRIP_SINGLE) begin
            strip_set[2*ri]   = data[STRIP_BITS-1:0];
            strip_set[2*ri+1] = data[CFG_DATA_W-1:STRIP_BITS];
        end else if (idx == REG_STRIP_SINGLE) begin
            strip_set[SETTING_STRIPS-1] = data[STRIP_BITS-1:0];
        end
    endtask

    // Program every strip from plan_set, optionally poking the unused indexes
    task automatic load_strips(input bit spare);
        for (int k = 0; k < NUM_PAIR_REGS; k++)
            write_reg(REG_PAIR_0 + CFG_ADDR_W'(k), {plan_set[2*k+1], plan_set[2*k]});
        write_reg(REG_STRIP_SINGLE, {STRIP_BITS'($urandom()), plan_set[SETTING_STRIPS-1]});
        if (spare) begin
            write_reg(REG_SPARE_6, CFG_DATA_W'({$urandom(), $urandom()}));
            write_reg(REG_SPARE_7, '1);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one word, hold it until taken, then queue what it should produce
    task automatic send_msg(input t_msg_word m, input t_check mode, input t_route_word typed);
        int gap;
        bit took;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_msg      <= m;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        case (mode)
            CHK_MODEL: split_message(m);
            CHK_ONE:   queue_copy(typed);
            default:   ;
        endcase
    endtask

    // Drop valid, drain every due copy, then let the chain empty out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_copies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_msg_word rand_msg();
        t_msg_word m;
        int r;
        r = $urandom_range(99);
        if (r < 45)
            m.status_byte = {($urandom_range(1) != 0) ? KIND_NOTE_ON : KIND_NOTE_OFF,
                             CHANNEL_W'($urandom())};
        else if (r < 55)
            m.status_byte = ($urandom_range(1) != 0) ? STATUS_CC_CH1 : STATUS_BEND_CH1;
        else if (r < 65)
            m.status_byte = {KIND_CONTROL, CHANNEL_16};
        else if (r < 80)
            m.status_byte = {($urandom_range(1) != 0) ? KIND_CONTROL : STATUS_BEND_CH1[7:4],
                             CHANNEL_W'($urandom())};
        else
            m.status_byte = STATUS_W'($urandom());
        r = $urandom_range(99);
        if (r < 8)       m.data_first = '0;
        else if (r < 16) m.data_first = DATA_MAX;
        else             m.data_first = DATA_W'($urandom());
        m.data_second = DATA_W'($urandom());
        if ($urandom_range(99) < 92) m.msg_length = LENGTH_W'($urandom_range(3, 1));
        else                         m.msg_length = LENGTH_W'($urandom());
        r = $urandom_range(99);
        if (r < 5)       m.time_offset = '0;
        else if (r < 10) m.time_offset = '1;
        else             m.time_offset = TIME_W'($urandom());
        return m;
    endfunction

    // Receiver: random stalls, with one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Sample both handshakes mid-cycle, check copies, watch for a hang
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_copy(o_route);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("** midi_split_zone_router: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        foreach (strip_set[s]) strip_set[s] = '0;
        foreach (plan_set[s]) plan_set[s] = '0;

        // Reset settings: every strip off, only channel-16 control gets through
        add_row(mk_msg(8'hBF, 7'h7F, 7'h00, 2'd3, 16'hFFFF), CHK_ONE,
                mk_copy(PORT_CONTROL, mk_msg(8'hBF, 7'h7F, 7'h00, 2'd3, 16'hFFFF)), 1'b0);
        add_row(mk_msg(8'hBF, 7'h00, 7'h7F, 2'd1, 16'h0000), CHK_ONE,
                mk_copy(PORT_CONTROL, mk_msg(8'hBF, 7'h00, 7'h7F, 2'd1, 16'h0000)), 1'b0);
        add_row(mk_msg(8'h90, 7'd60, 7'd100, 2'd3, 16'h1234), CHK_NONE, '0, 1'b0);
        add_row(mk_msg(8'hB0, 7'd7, 7'd64, 2'd3, 16'h0001), CHK_NONE, '0, 1'b0);
        add_row(mk_msg(8'hE0, 7'h7F, 7'h7F, 2'd3, 16'hFFFE), CHK_NONE, '0, 1'b0);
        add_row(mk_msg(8'h00, 7'h00, 7'h00, 2'd0, 16'h0000), CHK_NONE, '0, 1'b0);
        add_row(mk_msg(8'hFF, 7'h7F, 7'h7F, 2'd3, 16'hFFFF), CHK_NONE, '0, 1'b0);
        add_row(mk_msg(8'h3F, 7'h2A, 7'h55, 2'd2, 16'hA5A5), CHK_NONE, '0, 1'b0);
        // Zone settings: clamps at both ends, inverted and single-key ranges
        add_row(mk_msg(8'h90, 7'd0, 7'd127, 2'd3, 16'h0010), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'h95, 7'd127, 7'd1, 2'd3, 16'h0020), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'h80, 7'd60, 7'd0, 2'd3, 16'h0030), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'h9F, 7'd63, 7'd90, 2'd3, 16'hFFFF), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hB0, 7'd5, 7'd33, 2'd3, 16'h0040), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hE0, 7'h7F, 7'h40, 2'd3, 16'h0050), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hB5, 7'd10, 7'd12, 2'd3, 16'h0060), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hE3, 7'd70, 7'd70, 2'd3, 16'h0070), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hA2, 7'd70, 7'd5, 2'd3, 16'h0080), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hBF, 7'd64, 7'd1, 2'd3, 16'h0090), CHK_ONE,
                mk_copy(PORT_CONTROL, mk_msg(8'hBF, 7'd64, 7'd1, 2'd3, 16'h0090)), 1'b1);
        add_row(mk_msg(8'h00, 7'd60, 7'd9, 2'd0, 16'h0000), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'hF0, 7'd50, 7'd0, 2'd1, 16'h00A0), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'h91, 7'd20, 7'd80, 2'd3, 16'h00B0), CHK_MODEL, '0, 1'b1);
        add_row(mk_msg(8'h81, 7'd100, 7'd80, 2'd3, 16'h00C0), CHK_MODEL, '0, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed rows, switching to the zone settings once
        foreach (dir_rows[i]) begin
            if (dir_rows[i].zones && !zones_loaded) begin
                wait_idle();
                fill_plan(SET_ZONES);
                load_strips(1'b1);
                zones_loaded = 1'b1;
            end
            send_msg(dir_rows[i].msg, dir_rows[i].mode, dir_rows[i].copy);
        end

        // Random phases, each under its own strip settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            fill_plan(phase_set[p]);
            load_strips(1'($urandom_range(1)));
            if (p == PRESSURE_PHASE) hold_req = 1'b1;
            tx_idle_pct = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
            rx_idle_pct = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
            repeat ((phase_set[p] == SET_OFF) ? OFF_ITEMS : PHASE_ITEMS)
                send_msg(rand_msg(), CHK_MODEL, '0);
        end

        wait_idle();
        if (fail_count == 0 && due_copies.size() == 0) begin
            $display("** midi_split_zone_router: PASSED **");
        end else begin
            $display("** midi_split_zone_router: FAILED **");
        end
        $finish;
    end

endmodule
